// ===== rtl/cprgb_pkg.sv =====
// ----------------------------------------------------------------------------
// cprgb_pkg
// Types and constants shared by the camera pixel to RGB24 converter.
// ----------------------------------------------------------------------------
package cprgb_pkg;

  // source format register codes
  typedef enum logic [1:0] {
    FMT_BGR24 = 2'd0,
    FMT_RGBA32 = 2'd1,
    FMT_NV12 = 2'd2,
    FMT_YUYV = 2'd3
  } cprgb_fmt_e;

  localparam cprgb_fmt_e CprgbFmtReset = FMT_BGR24;

  // pixel lanes: first pixel and second (YUYV) pixel
  localparam int unsigned CprgbLanes = 2;

  // width of a fixed point channel term (worst case sum stays below 2^18)
  localparam int unsigned CprgbSumW = 19;

  // limited range matrix
  localparam logic signed [CprgbSumW-1:0] KNv12Y = 19'sd298;
  localparam logic signed [CprgbSumW-1:0] KNv12Rv = 19'sd409;
  localparam logic signed [CprgbSumW-1:0] KNv12Gu = 19'sd100;
  localparam logic signed [CprgbSumW-1:0] KNv12Gv = 19'sd208;
  localparam logic signed [CprgbSumW-1:0] KNv12Bu = 19'sd516;
  // full range matrix
  localparam logic signed [CprgbSumW-1:0] KYuyvRv = 19'sd359;
  localparam logic signed [CprgbSumW-1:0] KYuyvGu = 19'sd88;
  localparam logic signed [CprgbSumW-1:0] KYuyvGv = 19'sd183;
  localparam logic signed [CprgbSumW-1:0] KYuyvBu = 19'sd454;

  localparam logic [7:0] KLumaOfs = 8'd16;
  localparam logic [7:0] KChromaOfs = 8'd128;
  localparam logic [7:0] KChanMax = 8'd255;

  typedef logic signed [CprgbSumW-1:0] cprgb_term_t;

  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [7:0] byte_d;
    logic       frame_end;
  } cprgb_in_t;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       second_valid;
    logic       frame_end_out;
  } cprgb_out_t;

  // per pixel luma terms plus shared chroma terms
  typedef struct packed {
    cprgb_term_t [CprgbLanes-1:0] luma;
    cprgb_term_t                  rv;
    cprgb_term_t                  guv;
    cprgb_term_t                  bu;
    logic                         rnd;
  } cprgb_terms_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cprgb_pix_t;

endpackage

// ===== rtl/camera_pixel_to_rgb24_converter_core.sv =====
// ----------------------------------------------------------------------------
// camera_pixel_to_rgb24_converter_core
// Converts one camera source unit (BGR24, RGBA32, NV12, YUYV) to RGB24.
//
// Channel  Dir  Handshake          Payload
// input    in   start / busy       in_i  (cprgb_in_t)
// result   out  done_o strobe      res_o (cprgb_out_t)
// config   in   cfg_we_i           cfg_wdata_i (source format)
//
// One unit per clock while busy is low; the result strobe follows start through
// the product register and the lane sum register.
// busy is high only during and directly after reset.
// Results are not held: each is valid for the single cycle done_o is high.
// ----------------------------------------------------------------------------
module camera_pixel_to_rgb24_converter_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  cprgb_pkg::cprgb_in_t   in_i,
  output logic                   done_o,
  output cprgb_pkg::cprgb_out_t  res_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_wdata_i
);
  import cprgb_pkg::*;

  cprgb_fmt_e   fmt_q, fmt1_q, fmt2_q;
  logic         rdy_q, v1_q, v2_q, fe1_q, fe2_q;
  logic         accept;
  cprgb_terms_t terms;
  cprgb_pix_t   pix [CprgbLanes];
  cprgb_out_t   res;

  assign busy   = ~rdy_q;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= CprgbFmtReset;
      rdy_q <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      rdy_q <= 1'b1;
      v1_q  <= accept;
      v2_q  <= v1_q;
      if (cfg_we_i) begin
        fmt_q <= cprgb_fmt_e'(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fmt1_q <= fmt_q;
    fe1_q  <= in_i.frame_end;
    fmt2_q <= fmt1_q;
    fe2_q  <= fe1_q;
  end

  cprgb_terms u_terms (
    .clk_i   (clk_i),
    .fmt_i   (fmt_q),
    .in_i    (in_i),
    .terms_o (terms)
  );

  for (genvar l = 0; l < CprgbLanes; l++) begin : g_lane
    cprgb_lane u_lane (
      .clk_i  (clk_i),
      .luma_i (terms.luma[l]),
      .rv_i   (terms.rv),
      .guv_i  (terms.guv),
      .bu_i   (terms.bu),
      .rnd_i  (terms.rnd),
      .pix_o  (pix[l])
    );
  end

  // merge: second pixel only exists for YUYV pairs
  always_comb begin
    res = '0;
    res.red_first     = pix[0].red;
    res.green_first   = pix[0].green;
    res.blue_first    = pix[0].blue;
    res.frame_end_out = fe2_q;
    if (fmt2_q == FMT_YUYV) begin
      res.red_second   = pix[1].red;
      res.green_second = pix[1].green;
      res.blue_second  = pix[1].blue;
      res.second_valid = 1'b1;
    end
  end

  assign res_o  = res;
  assign done_o = v2_q;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(accept, 2))
    else $error("result strobe does not follow transfer by two cycles");

  a_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.second_valid) |->
      (res_o.red_second == 8'h00 && res_o.green_second == 8'h00 &&
       res_o.blue_second == 8'h00))
    else $error("second pixel not cleared outside YUYV");

  a_fe_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.frame_end_out == $past(in_i.frame_end, 2))
    else $error("frame end flag lost");

  a_rgb_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && fmt2_q == FMT_RGBA32) |->
      (res_o.red_first == $past(in_i.byte_a, 2) &&
       res_o.blue_first == $past(in_i.byte_c, 2)))
    else $error("RGBA pass-through mismatch");
`endif

endmodule

// ===== rtl/cprgb_terms.sv =====
// ----------------------------------------------------------------------------
// cprgb_terms
// Product stage: forms the luma and chroma terms for the selected format.
// ----------------------------------------------------------------------------
module cprgb_terms (
  input  logic                    clk_i,
  input  cprgb_pkg::cprgb_fmt_e   fmt_i,
  input  cprgb_pkg::cprgb_in_t    in_i,
  output cprgb_pkg::cprgb_terms_t terms_o
);
  import cprgb_pkg::*;

  cprgb_terms_t terms_d, terms_q;
  logic signed [9:0] cy, du, ev, yv;
  cprgb_term_t cy_w, du_w, ev_w, yv_w;

  always_comb begin
    cy = $signed({2'b00, in_i.byte_a}) - $signed({2'b00, KLumaOfs});
    du = $signed({2'b00, in_i.byte_b}) - $signed({2'b00, KChromaOfs});
    ev = $signed({2'b00, in_i.byte_c}) - $signed({2'b00, KChromaOfs});
    yv = $signed({2'b00, in_i.byte_d}) - $signed({2'b00, KChromaOfs});
    cy_w = CprgbSumW'(cy);
    du_w = CprgbSumW'(du);
    ev_w = CprgbSumW'(ev);
    yv_w = CprgbSumW'(yv);
  end

  always_comb begin
    terms_d = '0;
    case (fmt_i)
      FMT_BGR24: begin
        // pass-through as value * 256 so the lanes return it unchanged
        terms_d.rv  = cprgb_term_t'({in_i.byte_c, 8'h00});
        terms_d.guv = cprgb_term_t'({in_i.byte_b, 8'h00});
        terms_d.bu  = cprgb_term_t'({in_i.byte_a, 8'h00});
      end
      FMT_RGBA32: begin
        terms_d.rv  = cprgb_term_t'({in_i.byte_a, 8'h00});
        terms_d.guv = cprgb_term_t'({in_i.byte_b, 8'h00});
        terms_d.bu  = cprgb_term_t'({in_i.byte_c, 8'h00});
      end
      FMT_NV12: begin
        terms_d.luma[0] = cy_w * KNv12Y;
        terms_d.rv      = ev_w * KNv12Rv;
        terms_d.guv     = -(du_w * KNv12Gu) - (ev_w * KNv12Gv);
        terms_d.bu      = du_w * KNv12Bu;
        terms_d.rnd     = 1'b1;
      end
      FMT_YUYV: begin
        terms_d.luma[0] = cprgb_term_t'({in_i.byte_a, 8'h00});
        terms_d.luma[1] = cprgb_term_t'({in_i.byte_c, 8'h00});
        terms_d.rv      = yv_w * KYuyvRv;
        terms_d.guv     = -(du_w * KYuyvGu) - (yv_w * KYuyvGv);
        terms_d.bu      = du_w * KYuyvBu;
      end
      default: terms_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    terms_q <= terms_d;
  end

  assign terms_o = terms_q;

endmodule

// ===== rtl/cprgb_lane.sv =====
// ----------------------------------------------------------------------------
// cprgb_lane
// One pixel lane: adds luma and chroma terms, shifts by 8 and saturates.
// ----------------------------------------------------------------------------
module cprgb_lane (
  input  logic                  clk_i,
  input  cprgb_pkg::cprgb_term_t luma_i,
  input  cprgb_pkg::cprgb_term_t rv_i,
  input  cprgb_pkg::cprgb_term_t guv_i,
  input  cprgb_pkg::cprgb_term_t bu_i,
  input  logic                  rnd_i,
  output cprgb_pkg::cprgb_pix_t pix_o
);
  import cprgb_pkg::*;

  cprgb_pix_t pix_d, pix_q;
  cprgb_term_t rnd_w, sum_r, sum_g, sum_b;

  // floor shift by 8 then clamp to 0..255
  function automatic logic [7:0] sat_chan(input cprgb_term_t s);
    logic [7:0] r;
    if (s[CprgbSumW-1]) begin
      r = 8'h00;
    end else if (|s[CprgbSumW-2:16]) begin
      r = KChanMax;
    end else begin
      r = s[15:8];
    end
    return r;
  endfunction

  always_comb begin
    rnd_w = rnd_i ? cprgb_term_t'(KChromaOfs) : '0;
    sum_r = luma_i + rv_i + rnd_w;
    sum_g = luma_i + guv_i + rnd_w;
    sum_b = luma_i + bu_i + rnd_w;
    pix_d.red   = sat_chan(sum_r);
    pix_d.green = sat_chan(sum_g);
    pix_d.blue  = sat_chan(sum_b);
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign pix_o = pix_q;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the camera pixel to RGB24 converter. A short table
// of directed source units is run first, through all four source formats.
// Random phases follow, each one after a format write, with random sender
// gaps in all but the calm phases. Every result strobe is checked field by
// field against a typed table result or a local model of the conversion.
// ----------------------------------------------------------------------------
module tb;
  import cprgb_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomUnits = 1450;
  localparam int unsigned NumVectors = 18;

  typedef struct packed {
    cprgb_fmt_e fmt;
    cprgb_in_t  src;
    logic       typed;
    cprgb_out_t res;
  } vector_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  cprgb_in_t  in_i = '0;
  logic       done_o;
  cprgb_out_t res_o;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_wdata_i = 2'd0;

  cprgb_fmt_e  fmt_q = CprgbFmtReset;
  cprgb_out_t  pixels_q[$];
  vector_t     vectors[NumVectors];
  int unsigned n_units = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned n_writes = 0;
  int unsigned cycles = 0;

  always #5 clk_i = ~clk_i;

  camera_pixel_to_rgb24_converter_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  function automatic logic [7:0] clamp8(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // expected RGB24 result of one source unit; >>> on int floors
  function automatic cprgb_out_t convert_unit(cprgb_fmt_e fmt, cprgb_in_t src);
    cprgb_out_t p;
    int cy, du, ev, y0, y1, rv, guv, bu;
    p = '0;
    p.frame_end_out = src.frame_end;
    case (fmt)
      FMT_BGR24: begin
        p.red_first = src.byte_c;
        p.green_first = src.byte_b;
        p.blue_first = src.byte_a;
      end
      FMT_RGBA32: begin
        p.red_first = src.byte_a;
        p.green_first = src.byte_b;
        p.blue_first = src.byte_c;
      end
      FMT_NV12: begin
        cy = int'(src.byte_a) - 16;
        du = int'(src.byte_b) - 128;
        ev = int'(src.byte_c) - 128;
        p.red_first = clamp8((298 * cy + 409 * ev + 128) >>> 8);
        p.green_first = clamp8((298 * cy - 100 * du - 208 * ev + 128) >>> 8);
        p.blue_first = clamp8((298 * cy + 516 * du + 128) >>> 8);
      end
      default: begin
        y0 = int'(src.byte_a) * 256;
        y1 = int'(src.byte_c) * 256;
        du = int'(src.byte_b) - 128;
        ev = int'(src.byte_d) - 128;
        rv = 359 * ev;
        guv = -88 * du - 183 * ev;
        bu = 454 * du;
        p.red_first = clamp8((y0 + rv) >>> 8);
        p.green_first = clamp8((y0 + guv) >>> 8);
        p.blue_first = clamp8((y0 + bu) >>> 8);
        p.red_second = clamp8((y1 + rv) >>> 8);
        p.green_second = clamp8((y1 + guv) >>> 8);
        p.blue_second = clamp8((y1 + bu) >>> 8);
        p.second_valid = 1'b1;
      end
    endcase
    return p;
  endfunction

  // favors the range and offset corners of the matrices
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd16;
      3: return 8'd128;
      4: return 8'd235;
      default: return 8'($urandom());
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic push_unit(input cprgb_in_t src, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    in_i <= src;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pixels_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_format(input cprgb_fmt_e fmt);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= fmt;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    fmt_q = fmt;
    n_writes++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results pending", $time, cycles,
               pixels_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin : check_results
    cprgb_out_t want;
    string      bad;
    if (rst_ni && done_o === 1'b1) begin
      if (pixels_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, res_o);
      end else begin
        want = pixels_q.pop_front();
        n_checked++;
        bad = "";
        if (res_o.red_first !== want.red_first) bad = {bad, " red_first"};
        if (res_o.green_first !== want.green_first) bad = {bad, " green_first"};
        if (res_o.blue_first !== want.blue_first) bad = {bad, " blue_first"};
        if (res_o.red_second !== want.red_second) bad = {bad, " red_second"};
        if (res_o.green_second !== want.green_second) bad = {bad, " green_second"};
        if (res_o.blue_second !== want.blue_second) bad = {bad, " blue_second"};
        if (res_o.second_valid !== want.second_valid) bad = {bad, " second_valid"};
        if (res_o.frame_end_out !== want.frame_end_out) bad = {bad, " frame_end_out"};
        if (bad != "") begin
          n_errors++;
          $display("%0t: mismatch in%s, expected %h, actual %h", $time, bad, want, res_o);
        end
      end
    end
  end

  initial begin
    cprgb_in_t   src;
    int unsigned sent;
    int unsigned phase;
    int unsigned span;
    bit          calm;

    // pass-through formats: swap, drop alpha, zero second pixel
    vectors[0] = '{FMT_BGR24, '{8'h01, 8'h02, 8'h03, 8'hff, 1'b0}, 1'b1,
                   '{8'h03, 8'h02, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}};
    vectors[1] = '{FMT_BGR24, '{8'hff, 8'hff, 8'hff, 8'h00, 1'b1}, 1'b1,
                   '{8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1}};
    vectors[2] = '{FMT_BGR24, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, '0};
    vectors[3] = '{FMT_BGR24, '{8'haa, 8'h55, 8'hc3, 8'h5a, 1'b1}, 1'b0, '0};
    vectors[4] = '{FMT_RGBA32, '{8'hff, 8'h00, 8'h80, 8'haa, 1'b1}, 1'b1,
                   '{8'hff, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1}};
    vectors[5] = '{FMT_RGBA32, '{8'h00, 8'hff, 8'h00, 8'hff, 1'b0}, 1'b1,
                   '{8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}};
    vectors[6] = '{FMT_RGBA32, '{8'h12, 8'h34, 8'h56, 8'h00, 1'b0}, 1'b0, '0};
    // limited range: black and white points, then saturation both ways
    vectors[7] = '{FMT_NV12, '{8'd16, 8'd128, 8'd128, 8'hff, 1'b0}, 1'b1, '0};
    vectors[8] = '{FMT_NV12, '{8'd235, 8'd128, 8'd128, 8'h00, 1'b1}, 1'b1,
                   '{8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1}};
    vectors[9] = '{FMT_NV12, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0};
    vectors[10] = '{FMT_NV12, '{8'hff, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b0, '0};
    vectors[11] = '{FMT_NV12, '{8'hff, 8'h00, 8'hff, 8'h00, 1'b0}, 1'b0, '0};
    vectors[12] = '{FMT_NV12, '{8'h00, 8'hff, 8'h00, 8'hff, 1'b0}, 1'b0, '0};
    // pixel pair sharing one chroma pair
    vectors[13] = '{FMT_YUYV, '{8'h00, 8'h80, 8'hff, 8'h80, 1'b0}, 1'b1,
                    '{8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0}};
    vectors[14] = '{FMT_YUYV, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, '0};
    vectors[15] = '{FMT_YUYV, '{8'hff, 8'hff, 8'hff, 8'hff, 1'b0}, 1'b0, '0};
    vectors[16] = '{FMT_YUYV, '{8'h80, 8'h00, 8'h80, 8'hff, 1'b1}, 1'b0, '0};
    vectors[17] = '{FMT_YUYV, '{8'hff, 8'hff, 8'h00, 8'h00, 1'b0}, 1'b0, '0};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // first rows run at the reset format, without a write
    foreach (vectors[i]) begin
      if (vectors[i].fmt != fmt_q) begin
        drain();
        set_format(vectors[i].fmt);
      end
      push_unit(vectors[i].src, $urandom_range(0, 11));
      pixels_q.push_back(vectors[i].typed ? vectors[i].res
                                          : convert_unit(fmt_q, vectors[i].src));
      n_units++;
    end

    // each phase drains the pipe before its format write
    sent = 0;
    phase = 0;
    while (sent < RandomUnits) begin
      drain();
      if (phase < 4) set_format(cprgb_fmt_e'(2'((phase + 3) % 4)));
      else set_format(cprgb_fmt_e'(2'($urandom_range(0, 3))));
      span = $urandom_range(40, 160);
      if (span > RandomUnits - sent) span = RandomUnits - sent;
      calm = ($urandom_range(0, 3) == 0);
      repeat (span) begin
        src.byte_a = pick_byte();
        src.byte_b = pick_byte();
        src.byte_c = pick_byte();
        src.byte_d = pick_byte();
        src.frame_end = ($urandom_range(0, 9) == 0);
        push_unit(src, calm ? 0 : $urandom_range(0, 11));
        pixels_q.push_back(convert_unit(fmt_q, src));
        n_units++;
        sent++;
      end
      phase++;
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (pixels_q.size() != 0) begin
      n_errors += pixels_q.size();
      $display("%0t: %0d expected results never arrived", $time, pixels_q.size());
    end
    $display("%0d source units sent, %0d results checked, %0d format writes, %0d phases",
             n_units, n_checked, n_writes, phase);
    $display("all four source formats ran with bursts, random gaps and drained pauses");
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
